@@ hw/rtl/wpp_pkg.sv @@
// Shared types and constants for the WAV PCM16 stream parser.
// Holds the byte and result item structs, event and error codes, and tag bytes.
// No dependencies.
`default_nettype none

package wpp_pkg;

  // One byte of the file stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         event_res;
    logic signed [15:0] sample_value;
    logic [15:0]        channel_index;
    logic [31:0]        rate_hz;
    logic [15:0]        channel_count;
    logic [30:0]        frame_count;
    logic [2:0]         error_code;
    logic               last;
  } res_t;

  // Up to two results made by one accepted byte, in order.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Event codes.
  localparam logic [1:0] EV_SAMPLE  = 2'd0;
  localparam logic [1:0] EV_SUMMARY = 2'd1;
  localparam logic [1:0] EV_ERROR   = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_HEADER    = 3'd0;
  localparam logic [2:0] ERR_FMT_SHORT = 3'd1;
  localparam logic [2:0] ERR_FORMAT    = 3'd2;
  localparam logic [2:0] ERR_DATA_SHORT = 3'd3;
  localparam logic [2:0] ERR_NO_DATA   = 3'd4;

  // Tags and chunk ids (ids as little-endian words).
  localparam logic [7:0]  TAG_RIFF [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0]  TAG_WAVE [4] = '{8'h57, 8'h41, 8'h56, 8'h45};
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_BODY = 32'd16;
  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] PCM_BITS = 16'd16;

  // Result queue depth.
  localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

@@ hw/rtl/wav_pcm16_stream_parser_top.sv @@
// Results: the results of an accepted byte are written into the result queue and are
// offered from it in order, the first result of a pair ahead of the second.
// Throughput: one byte per cycle; a byte may yield up to two results, held in a
// four-entry result queue, and the byte side stalls while fewer than two entries are free.
// Reset: synchronous; parsing returns to expecting the RIFF tag and the queue empties.
// Depends on wpp_pkg, wpp_core and wpp_fifo.
`default_nettype none

module wav_pcm16_stream_parser_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_valid,
  output logic               byte_stall,
  input  wpp_pkg::in_t       byte_item,
  output logic               result_valid,
  input  wire logic          result_stall,
  output wpp_pkg::res_t      result_item
);
  import wpp_pkg::*;

  push_t push;
  logic  accept;

  assign accept = byte_valid && !byte_stall;

  // Byte decode and parse state.
  wpp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_item),
    .push   (push)
  );

  // Result queue between decode and the result port.
  wpp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (byte_stall),
    .valid (result_valid),
    .stall (result_stall),
    .item  (result_item)
  );

endmodule

`default_nettype wire

@@ hw/rtl/wpp_core.sv @@
// Parse state and per-byte decode for the WAV PCM16 stream parser.
// Each accepted byte updates the parse registers and yields up to two results.
// Depends on wpp_pkg.
`default_nettype none

module wpp_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wpp_pkg::in_t       item,
  output wpp_pkg::push_t     push
);
  import wpp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD, PH_CHDR, PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  bcnt, bcnt_next;
  logic [31:0] fshift, fshift_next;
  logic [31:0] clen, clen_next;
  logic [31:0] drem, drem_next;
  logic [15:0] ftag, ftag_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [15:0] sbits, sbits_next;
  logic        fseen, fseen_next;
  logic [7:0]  lowb, lowb_next;
  logic [15:0] chpos, chpos_next;
  logic [30:0] frames, frames_next;

  logic        end_valid;
  res_t        end_res;
  logic        sample_valid;
  res_t        sample_res;

  // Byte decode: a first byte starts from cleared state, then the phase acts on it.
  always_comb begin
    phase_t      c_phase;
    logic [4:0]  c_bcnt;
    logic [31:0] c_fshift, c_clen, c_drem, c_rate;
    logic [15:0] c_ftag, c_chans, c_sbits, c_chpos, pos1;
    logic        c_fseen;
    logic [7:0]  c_lowb, b;
    logic [30:0] c_frames;
    logic        proc_end;
    res_t        proc_res;

    b        = item.data_byte;
    c_phase  = item.first_byte ? PH_HEAD : phase;
    c_bcnt   = item.first_byte ? '0 : bcnt;
    c_fshift = item.first_byte ? '0 : fshift;
    c_clen   = item.first_byte ? '0 : clen;
    c_drem   = item.first_byte ? '0 : drem;
    c_ftag   = item.first_byte ? '0 : ftag;
    c_chans  = item.first_byte ? '0 : chans;
    c_rate   = item.first_byte ? '0 : rate;
    c_sbits  = item.first_byte ? '0 : sbits;
    c_fseen  = item.first_byte ? 1'b0 : fseen;
    c_lowb   = item.first_byte ? '0 : lowb;
    c_chpos  = item.first_byte ? '0 : chpos;
    c_frames = item.first_byte ? '0 : frames;
    pos1     = c_chpos + 16'd1;

    phase_next  = c_phase;
    bcnt_next   = c_bcnt;
    fshift_next = c_fshift;
    clen_next   = c_clen;
    drem_next   = c_drem;
    ftag_next   = c_ftag;
    chans_next  = c_chans;
    rate_next   = c_rate;
    sbits_next  = c_sbits;
    fseen_next  = c_fseen;
    lowb_next   = c_lowb;
    chpos_next  = c_chpos;
    frames_next = c_frames;

    proc_end     = 1'b0;
    proc_res     = '0;
    sample_valid = 1'b0;
    sample_res   = '0;

    unique case (c_phase)
      // RIFF tag, size bytes, WAVE tag.
      PH_HEAD: begin
        if ((c_bcnt < 5'd4 && b != TAG_RIFF[c_bcnt[1:0]]) ||
            (c_bcnt >= 5'd8 && b != TAG_WAVE[c_bcnt[1:0]])) begin
          proc_end            = 1'b1;
          proc_res.event_res  = EV_ERROR;
          proc_res.error_code = ERR_HEADER;
          phase_next          = PH_DONE;
        end else if (c_bcnt >= 5'd11) begin
          phase_next  = PH_CHDR;
          bcnt_next   = '0;
          fshift_next = '0;
          clen_next   = '0;
        end else begin
          bcnt_next = c_bcnt + 5'd1;
        end
      end
      // Chunk header: id then length, both little-endian.
      PH_CHDR: begin
        if (c_bcnt < 5'd4) begin
          fshift_next[8*c_bcnt[1:0] +: 8] = b;
        end else begin
          clen_next[8*c_bcnt[1:0] +: 8] = b;
        end
        bcnt_next = c_bcnt + 5'd1;
        if (c_bcnt == 5'd7) begin
          bcnt_next = '0;
          if (c_fshift == ID_FMT) begin
            phase_next = PH_FMT;
            ftag_next  = '0;
            chans_next = '0;
            rate_next  = '0;
            sbits_next = '0;
          end else if (c_fshift == ID_DATA) begin
            if (!c_fseen || c_ftag != FMT_PCM || c_sbits != PCM_BITS ||
                c_chans == 16'd0) begin
              proc_end            = 1'b1;
              proc_res.event_res  = EV_ERROR;
              proc_res.error_code = ERR_FORMAT;
              phase_next          = PH_DONE;
            end else begin
              phase_next  = PH_DATA;
              drem_next   = clen_next;
              chpos_next  = '0;
              frames_next = '0;
              if (clen_next == 32'd0) begin
                proc_end               = 1'b1;
                proc_res.event_res     = EV_SUMMARY;
                proc_res.rate_hz       = c_rate;
                proc_res.channel_count = c_chans;
                proc_res.frame_count   = '0;
                phase_next             = PH_DONE;
              end
            end
          end else begin
            drem_next = clen_next;
            if (clen_next == 32'd0) begin
              phase_next  = PH_CHDR;
              fshift_next = '0;
              clen_next   = '0;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
      end
      // Format body: sixteen bytes are read, and any longer body is skipped.
      PH_FMT: begin
        if (c_bcnt < 5'd2) begin
          ftag_next[8*c_bcnt[0] +: 8] = b;
        end else if (c_bcnt < 5'd4) begin
          chans_next[8*c_bcnt[0] +: 8] = b;
        end else if (c_bcnt < 5'd8) begin
          rate_next[8*c_bcnt[1:0] +: 8] = b;
        end else if (c_bcnt >= 5'd14) begin
          sbits_next[8*c_bcnt[0] +: 8] = b;
        end
        bcnt_next = c_bcnt + 5'd1;
        if (c_bcnt == 5'd15) begin
          fseen_next = 1'b1;
          if (c_clen > FMT_BODY) begin
            drem_next  = c_clen - FMT_BODY;
            clen_next  = '0;
            phase_next = PH_SKIP;
          end else begin
            phase_next  = PH_CHDR;
            bcnt_next   = '0;
            fshift_next = '0;
            clen_next   = '0;
          end
        end
      end
      // Skipped chunk body, then a pad byte when an unknown chunk's length is odd.
      PH_SKIP: begin
        drem_next = c_drem - 32'd1;
        if (drem_next == 32'd0) begin
          if (c_clen[0]) begin
            phase_next = PH_PAD;
          end else begin
            phase_next  = PH_CHDR;
            bcnt_next   = '0;
            fshift_next = '0;
            clen_next   = '0;
          end
        end
      end
      PH_PAD: begin
        phase_next  = PH_CHDR;
        bcnt_next   = '0;
        fshift_next = '0;
        clen_next   = '0;
      end
      // Sample data: low byte held, high byte completes a sample.
      PH_DATA: begin
        if (!c_bcnt[0]) begin
          lowb_next = b;
        end else begin
          sample_valid             = 1'b1;
          sample_res.event_res     = EV_SAMPLE;
          sample_res.sample_value  = {b, c_lowb};
          sample_res.channel_index = c_chpos;
          if (pos1 >= c_chans) begin
            chpos_next  = '0;
            frames_next = c_frames + 31'd1;
          end else begin
            chpos_next = pos1;
          end
        end
        bcnt_next = {4'd0, ~c_bcnt[0]};
        drem_next = c_drem - 32'd1;
        if (drem_next == 32'd0) begin
          proc_end               = 1'b1;
          proc_res.event_res     = EV_SUMMARY;
          proc_res.rate_hz       = c_rate;
          proc_res.channel_count = c_chans;
          proc_res.frame_count   = frames_next;
          phase_next             = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // End of file before a summary or error: report by where parsing stopped.
    end_valid = proc_end;
    end_res   = proc_res;
    if (!proc_end && item.last_byte && phase_next != PH_DONE) begin
      end_valid         = 1'b1;
      end_res           = '0;
      end_res.event_res = EV_ERROR;
      priority if (phase_next == PH_HEAD) begin
        end_res.error_code = ERR_HEADER;
      end else if (phase_next == PH_FMT) begin
        end_res.error_code = ERR_FMT_SHORT;
      end else if (phase_next == PH_DATA) begin
        end_res.error_code = ERR_DATA_SHORT;
      end else begin
        end_res.error_code = ERR_NO_DATA;
      end
      phase_next = PH_DONE;
    end
  end

  // Order the results and mark the final one.
  always_comb begin
    push = '0;
    if (accept) begin
      push.count = {1'b0, sample_valid} + {1'b0, end_valid};
    end
    push.r0      = sample_valid ? sample_res : end_res;
    push.r0.last = !(sample_valid && end_valid);
    push.r1      = end_res;
    push.r1.last = 1'b1;
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEAD;
      bcnt   <= '0;
      fshift <= '0;
      clen   <= '0;
      drem   <= '0;
      ftag   <= '0;
      chans  <= '0;
      rate   <= '0;
      sbits  <= '0;
      fseen  <= 1'b0;
      lowb   <= '0;
      chpos  <= '0;
      frames <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      bcnt   <= bcnt_next;
      fshift <= fshift_next;
      clen   <= clen_next;
      drem   <= drem_next;
      ftag   <= ftag_next;
      chans  <= chans_next;
      rate   <= rate_next;
      sbits  <= sbits_next;
      fseen  <= fseen_next;
      lowb   <= lowb_next;
      chpos  <= chpos_next;
      frames <= frames_next;
    end
  end

  // A summary or an error always closes the file.
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && end_valid) |=> (phase == PH_DONE))
    else $error("parser left open after summary or error");

  // In the data body the counter only toggles between low and high byte.
  a_data_toggle: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bcnt <= 5'd1))
    else $error("byte counter out of range in data body");

  // Two results from one byte always lead with a sample.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (push.r0.event_res == EV_SAMPLE && push.r1.last))
    else $error("result pair out of order");

endmodule

`default_nettype wire

@@ hw/rtl/wpp_fifo.sv @@
// Result queue for the WAV PCM16 stream parser.
// Takes up to two results per cycle, hands out one per cycle while not stalled. Depends on wpp_pkg.
`default_nettype none

module wpp_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wpp_pkg::push_t     push,
  output logic               full,
  output logic               valid,
  input  wire logic          stall,
  output wpp_pkg::res_t      item
);
  import wpp_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  res_t            mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count, count_next;
  logic            pop;

  // Room for a full pair is kept before another byte is taken.
  assign full  = count > CntW'(QUEUE_DEPTH - 2);
  assign valid = count != '0;
  assign item  = mem[rd_ptr];
  assign pop   = valid && !stall;
  assign count_next = count + CntW'(push.count) - CntW'(pop);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PtrW'(1)] <= push.r1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.count);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= CntW'(QUEUE_DEPTH - 2)))
    else $error("push into queue without room");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (valid && !stall && push.count == 2'd0) |=> (count == $past(count) - CntW'(1)))
    else $error("queue count did not drop on pop");

endmodule

`default_nettype wire
